[sv/mbe_pkg.sv]
// ----------------------------------------------------------------------------
// mbe_pkg: shared types and constants for the Mandelbrot escape-time unit
// Holds the fixed-point format, the register map, the payload words and the
// command and status words that join the controller to the datapath.
// ----------------------------------------------------------------------------
package mbe_pkg;

    // Fixed-point format: signed Q5.27 on 32 bits by default.
    localparam int FRACTION_BITS = 27;
    localparam int MAX_COLUMNS   = 1024;
    localparam int MAX_ROWS      = 1024;

    // Register map of the configuration port.
    localparam logic [1:0] REG_X_ORIGIN        = 2'd0;
    localparam logic [1:0] REG_Y_ORIGIN        = 2'd1;
    localparam logic [1:0] REG_STEP_SIZE       = 2'd2;
    localparam logic [1:0] REG_ITERATION_LIMIT = 2'd3;

    localparam int CFG_DATA_W = 30;

    // Reset values of the registers.
    localparam logic signed [29:0] X_ORIGIN_RST        = -30'sd268435456;
    localparam logic signed [29:0] Y_ORIGIN_RST        = -30'sd134217728;
    localparam logic        [27:0] STEP_SIZE_RST       = 28'd671089;
    localparam logic        [7:0]  ITERATION_LIMIT_RST = 8'd255;

    // Input word: one pixel.
    typedef struct packed {
        logic [9:0] column;
        logic [9:0] row;
    } pixel_t;

    // Result word: escape count with the pixel it belongs to.
    typedef struct packed {
        logic [7:0] iteration_count;
        logic [9:0] column_out;
        logic [9:0] row_out;
    } result_t;

    // Current register contents.
    typedef struct packed {
        logic signed [29:0] x_origin;
        logic signed [29:0] y_origin;
        logic        [27:0] step_size;
        logic        [7:0]  iteration_limit;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the pixel word
        logic setup;  // form c, clear z and the count
        logic step;   // run one iteration
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic finish; // escaped or the iteration limit is reached
    } status_t;

endpackage

[sv/mbe_regs.sv]
// ----------------------------------------------------------------------------
// mbe_regs: configuration registers
// Four write-only registers loaded through a plain write port.
// ----------------------------------------------------------------------------
module mbe_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [1:0]                     cfg_index,
    input  logic [mbe_pkg::CFG_DATA_W-1:0] cfg_data,
    output mbe_pkg::cfg_t                  cfg
);

    mbe_pkg::cfg_t cfg_reg;
    mbe_pkg::cfg_t cfg_next;

    // Decode the register index and take the low bits of the write data.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                mbe_pkg::REG_X_ORIGIN:        cfg_next.x_origin = cfg_data[29:0];
                mbe_pkg::REG_Y_ORIGIN:        cfg_next.y_origin = cfg_data[29:0];
                mbe_pkg::REG_STEP_SIZE:       cfg_next.step_size = cfg_data[27:0];
                mbe_pkg::REG_ITERATION_LIMIT: cfg_next.iteration_limit = cfg_data[7:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_origin        <= mbe_pkg::X_ORIGIN_RST;
            cfg_reg.y_origin        <= mbe_pkg::Y_ORIGIN_RST;
            cfg_reg.step_size       <= mbe_pkg::STEP_SIZE_RST;
            cfg_reg.iteration_limit <= mbe_pkg::ITERATION_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[sv/mbe_ctrl.sv]
// ----------------------------------------------------------------------------
// mbe_ctrl: sequencing state machine
// Walks each pixel through setup, the iteration loop and the result strobe.
// ----------------------------------------------------------------------------
module mbe_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  mbe_pkg::status_t status,
    output mbe_pkg::cmd_t    cmd,
    output logic             busy,
    output logic             done
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_ITER  = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    // A new word may be taken while idle or while the result is shown.
    assign busy   = (state_reg == ST_SETUP) || (state_reg == ST_ITER);
    assign done   = (state_reg == ST_OUT);
    assign accept = start && !busy;

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE, ST_OUT:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETUP;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = ST_ITER;
            end
            ST_ITER:
            begin
                if (status.finish)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // The strobe never lasts more than one cycle.
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe held for two cycles");

    // An accepted word always goes to setup next.
    assert property (@(posedge clk) disable iff (!rst_n)
                     accept |=> (state_reg == ST_SETUP))
        else $error("accepted word did not enter setup");

    // A result follows only the end of the iteration loop.
    assert property (@(posedge clk) disable iff (!rst_n)
                     done |-> ($past(state_reg) == ST_ITER))
        else $error("result strobe without a finished loop");

    // The loop never iterates once it has finished.
    assert property (@(posedge clk) disable iff (!rst_n)
                     cmd.step |-> !status.finish)
        else $error("iteration issued after finish");

endmodule

[sv/mbe_dp.sv]
// ----------------------------------------------------------------------------
// mbe_dp: escape-time datapath
// Forms the point c from the pixel indices and runs z = z*z + c one
// iteration per cycle, counting iterations until escape or the limit.
// ----------------------------------------------------------------------------
module mbe_dp (
    input  logic             clk,
    input  logic             rst_n,
    input  mbe_pkg::cfg_t    cfg,
    input  mbe_pkg::pixel_t  pixel,
    input  mbe_pkg::cmd_t    cmd,
    output mbe_pkg::status_t status,
    output mbe_pkg::result_t result
);

    localparam int FB = mbe_pkg::FRACTION_BITS;

    // Largest usable index on each axis.
    localparam logic [11:0] COL_LAST = 12'(mbe_pkg::MAX_COLUMNS - 1);
    localparam logic [11:0] ROW_LAST = 12'(mbe_pkg::MAX_ROWS - 1);

    // 4.0 in the fixed-point format, at the widths where it is compared.
    localparam logic signed [41:0] FOUR42 = 42'sd4 <<< FB;
    localparam logic signed [63:0] FOUR64 = 64'sd4 <<< FB;

    localparam logic signed [63:0] I32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] I32_MIN = -64'sd2147483648;

    // Point coordinate: origin plus index times step, held to +-4.0.
    function automatic logic signed [31:0] coord(
        input logic signed [29:0] origin,
        input logic        [11:0] idx,
        input logic        [27:0] step
    );
        logic        [39:0] prod;
        logic signed [41:0] sum;
        prod = idx * step;
        sum  = 42'(origin) + $signed({2'b00, prod});
        if (sum > FOUR42)
            return 32'(FOUR42);
        else if (sum < -FOUR42)
            return 32'(-FOUR42);
        else
            return sum[31:0];
    endfunction

    // Saturate a wide sum to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > I32_MAX)
            return 32'(I32_MAX);
        else if (v < I32_MIN)
            return 32'(I32_MIN);
        else
            return v[31:0];
    endfunction

    logic [9:0]         column_reg;
    logic [9:0]         row_reg;
    logic signed [31:0] cx_reg;
    logic signed [31:0] cy_reg;
    logic signed [31:0] zx_reg;
    logic signed [31:0] zy_reg;
    logic [7:0]         count_reg;
    logic [7:0]         count_next;

    logic [11:0]        idx_x;
    logic [11:0]        idx_y;
    logic signed [63:0] pxx;
    logic signed [63:0] pyy;
    logic signed [63:0] pxy;
    logic signed [63:0] xx;
    logic signed [63:0] yy;
    logic signed [63:0] nx;
    logic signed [63:0] ny;
    logic               escape;

    // Clip indices past the frame edge.
    always_comb
    begin
        idx_x = ({2'b00, column_reg} > COL_LAST) ? COL_LAST : {2'b00, column_reg};
        idx_y = ({2'b00, row_reg} > ROW_LAST) ? ROW_LAST : {2'b00, row_reg};
    end

    // One iteration: three products, escape test and the new z.
    always_comb
    begin
        pxx    = zx_reg * zx_reg;
        pyy    = zy_reg * zy_reg;
        pxy    = zx_reg * zy_reg;
        xx     = pxx >>> FB;
        yy     = pyy >>> FB;
        escape = (xx + yy) >= FOUR64;
        nx     = xx - yy + 64'(cx_reg);
        ny     = (pxy >>> (FB - 1)) + 64'(cy_reg);
    end

    assign count_next    = count_reg + 8'd1;
    assign status.finish = (count_reg >= cfg.iteration_limit) || escape;

    // Pixel capture, point setup and the iteration registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            column_reg <= pixel.column;
            row_reg    <= pixel.row;
        end
        if (cmd.setup)
        begin
            cx_reg <= coord(cfg.x_origin, idx_x, cfg.step_size);
            cy_reg <= coord(cfg.y_origin, idx_y, cfg.step_size);
            zx_reg <= '0;
            zy_reg <= '0;
        end
        else if (cmd.step)
        begin
            zx_reg <= sat32(nx);
            zy_reg <= sat32(ny);
        end
    end

    // Iteration count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.setup)
        begin
            count_reg <= '0;
        end
        else if (cmd.step)
        begin
            count_reg <= count_next;
        end
    end

    assign result.iteration_count = count_reg;
    assign result.column_out      = column_reg;
    assign result.row_out         = row_reg;

    // The loop stops at the limit, so the count never passes it while running.
    assert property (@(posedge clk) disable iff (!rst_n)
                     cmd.step |-> (count_reg < cfg.iteration_limit))
        else $error("iteration count ran past the limit");

endmodule

[sv/mandelbrot_escape_time.sv]
// ----------------------------------------------------------------------------
// mandelbrot_escape_time: escape-time count for one pixel at a time
// After a pixel is accepted, the controller steps through setup and the
// iteration loop, one iteration per cycle until escape or the limit, and
// then raises done. No new pixel is taken while busy; a new start is
// taken in the cycle the result is shown.
// Reset clears the controller to idle and loads the register reset values;
// the result is shown for one cycle only, as the receiver cannot stall.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [1:0]                     cfg_index,
    input  logic [mbe_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           start,
    input  mbe_pkg::pixel_t                pixel,
    output logic                           busy,
    output logic                           done,
    output mbe_pkg::result_t               result
);

    mbe_pkg::cfg_t    cfg;
    mbe_pkg::cmd_t    cmd;
    mbe_pkg::status_t status;

    // Configuration registers.
    mbe_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Sequencer.
    mbe_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // Arithmetic.
    mbe_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .pixel  (pixel),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

endmodule

[test/mandelbrot_escape_time_test.sv]
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_test: self-checking bench for the escape-time unit
// Walks a directed table that covers the register extremes, zero limit, zero
// step, saturated points and the pixel index corners, then runs random phases.
// Each phase loads random registers and sends random pixels. An in-bench
// predictor computes each count that the plan does not give, and each result word is checked against
// the oldest pending word.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int    RANDOM_PHASES   = 10;
    localparam int    PHASE_PIXELS    = 170;
    localparam int    STALL_LIMIT     = 4000;
    localparam int    SETTLE_CYCLES   = 300;
    localparam longint FOUR_FIX       = longint'(4) <<< mbe_pkg::FRACTION_BITS;
    localparam longint Z_HIGH         = 64'sd2147483647;
    localparam longint Z_LOW          = -Z_HIGH - 1;

    typedef enum logic {ROW_PIXEL, ROW_CONFIG} row_kind_t;

    // One line of the directed plan: a register write or a pixel, with an
    // optional count that is obvious without running the iteration.
    typedef struct packed {
        row_kind_t  kind;
        logic [1:0] reg_index;
        logic [29:0] value;
        logic [9:0] column;
        logic [9:0] row;
        logic       has_known;
        logic [7:0] known_count;
    } plan_row_t;

    localparam int PLAN_ROWS = 31;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_write;
    logic [1:0]                     cfg_index;
    logic [mbe_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           start;
    mbe_pkg::pixel_t                pixel;
    logic                           busy;
    logic                           done;
    mbe_pkg::result_t               result;

    // Mirror of the register file as the predictor sees it.
    longint mirror_x_origin;
    longint mirror_y_origin;
    longint mirror_step;
    int     mirror_limit;

    mbe_pkg::result_t awaited_results[$];
    int      failures;
    int      stall_cycles;
    bit      cfg_open;

    plan_row_t directed_plan [0:PLAN_ROWS-1] = '{
        // Reset values, index corners and alternating bit patterns.
        '{ROW_PIXEL, mbe_pkg::REG_X_ORIGIN, 30'd0,         10'd0, 10'd0, 1'b0, 8'd0},
        '{ROW_PIXEL, mbe_pkg::REG_X_ORIGIN, 30'd0,         10'd1023, 10'd1023, 1'b0, 8'd0},
        '{ROW_PIXEL, mbe_pkg::REG_X_ORIGIN, 30'd0,         10'd1023, 10'd0, 1'b0, 8'd0},
        '{ROW_PIXEL, mbe_pkg::REG_X_ORIGIN, 30'd0,         10'd0, 10'd1023, 1'b0, 8'd0},
        '{ROW_PIXEL, mbe_pkg::REG_X_ORIGIN, 30'd0,         10'd682, 10'd341, 1'b0, 8'd0},
        '{ROW_PIXEL, mbe_pkg::REG_X_ORIGIN, 30'd0,         10'd341, 10'd682, 1'b0, 8'd0},
        // A zero limit does no iteration at all.
        '{ROW_CONFIG, mbe_pkg::REG_ITERATION_LIMIT, 30'd0, 10'd0, 10'd0, 1'b0, 8'd0},
        '{ROW_PIXEL, mbe_pkg::REG_X_ORIGIN, 30'd0,         10'd0, 10'd0, 1'b1, 8'd0},
        '{ROW_PIXEL, mbe_pkg::REG_X_ORIGIN, 30'd0,         10'd1023, 10'd1023, 1'b1, 8'd0},
        // A limit of one always completes the first iteration from z = 0.
        '{ROW_CONFIG, mbe_pkg::REG_ITERATION_LIMIT, 30'd1, 10'd0, 10'd0, 1'b0, 8'd0},
        '{ROW_PIXEL, mbe_pkg::REG_X_ORIGIN, 30'd0,         10'd300, 10'd700, 1'b1, 8'd1},
        // Zero step at the origin keeps z at zero, so the limit is reached.
        '{ROW_CONFIG, mbe_pkg::REG_X_ORIGIN, 30'd0,        10'd0, 10'd0, 1'b0, 8'd0},
        '{ROW_CONFIG, mbe_pkg::REG_Y_ORIGIN, 30'd0,        10'd0, 10'd0, 1'b0, 8'd0},
        '{ROW_CONFIG, mbe_pkg::REG_STEP_SIZE, 30'd0,       10'd0, 10'd0, 1'b0, 8'd0},
        '{ROW_CONFIG, mbe_pkg::REG_ITERATION_LIMIT, 30'd255, 10'd0, 10'd0, 1'b0, 8'd0},
        '{ROW_PIXEL, mbe_pkg::REG_X_ORIGIN, 30'd0,         10'd0, 10'd0, 1'b1, 8'd255},
        '{ROW_PIXEL, mbe_pkg::REG_X_ORIGIN, 30'd0,         10'd1023, 10'd1023, 1'b1, 8'd255},
        // Largest origins and step: c sits just below +4.0 at index zero and saturates at +4.0 further out.
        '{ROW_CONFIG, mbe_pkg::REG_X_ORIGIN, 30'h1FFF_FFFF, 10'd0, 10'd0, 1'b0, 8'd0},
        '{ROW_CONFIG, mbe_pkg::REG_Y_ORIGIN, 30'h1FFF_FFFF, 10'd0, 10'd0, 1'b0, 8'd0},
        '{ROW_CONFIG, mbe_pkg::REG_STEP_SIZE, 30'h0FFF_FFFF, 10'd0, 10'd0, 1'b0, 8'd0},
        '{ROW_PIXEL, mbe_pkg::REG_X_ORIGIN, 30'd0,         10'd0, 10'd0, 1'b0, 8'd0},
        '{ROW_PIXEL, mbe_pkg::REG_X_ORIGIN, 30'd0,         10'd1023, 10'd1023, 1'b0, 8'd0},
        // Most negative origins: c sits at -4.0 near column and row zero.
        '{ROW_CONFIG, mbe_pkg::REG_X_ORIGIN, 30'h2000_0000, 10'd0, 10'd0, 1'b0, 8'd0},
        '{ROW_CONFIG, mbe_pkg::REG_Y_ORIGIN, 30'h2000_0000, 10'd0, 10'd0, 1'b0, 8'd0},
        '{ROW_PIXEL, mbe_pkg::REG_X_ORIGIN, 30'd0,         10'd0, 10'd0, 1'b0, 8'd0},
        '{ROW_PIXEL, mbe_pkg::REG_X_ORIGIN, 30'd0,         10'd1023, 10'd1023, 1'b0, 8'd0},
        // Back to the usual view with the finest step.
        '{ROW_CONFIG, mbe_pkg::REG_X_ORIGIN, 30'h3000_0000, 10'd0, 10'd0, 1'b0, 8'd0},
        '{ROW_CONFIG, mbe_pkg::REG_Y_ORIGIN, 30'h3800_0000, 10'd0, 10'd0, 1'b0, 8'd0},
        '{ROW_CONFIG, mbe_pkg::REG_STEP_SIZE, 30'd1,       10'd0, 10'd0, 1'b0, 8'd0},
        '{ROW_PIXEL, mbe_pkg::REG_X_ORIGIN, 30'd0,         10'd512, 10'd512, 1'b0, 8'd0},
        '{ROW_PIXEL, mbe_pkg::REG_X_ORIGIN, 30'd0,         10'd1023, 10'd1023, 1'b0, 8'd0}
    };

    mandelbrot_escape_time i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .start     (start),
        .pixel     (pixel),
        .busy      (busy),
        .done      (done),
        .result    (result)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint clamp(longint v, longint lo, longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // One axis of c: index past the frame is pinned to the last pixel, then
    // the point is saturated to plus or minus 4.0.
    function automatic longint axis_point(longint origin, logic [9:0] index,
                                          longint frame);
        longint pos;
        pos = longint'(index);
        if (pos > frame - 1)
            pos = frame - 1;
        return clamp(origin + pos * mirror_step, -FOUR_FIX, FOUR_FIX);
    endfunction

    // Escape-time count for one pixel under the mirrored registers.
    function automatic logic [7:0] escape_count(mbe_pkg::pixel_t px);
        longint cx;
        longint cy;
        longint zx;
        longint zy;
        longint xx;
        longint yy;
        longint nx;
        longint ny;
        int     n;
        cx = axis_point(mirror_x_origin, px.column, longint'(mbe_pkg::MAX_COLUMNS));
        cy = axis_point(mirror_y_origin, px.row, longint'(mbe_pkg::MAX_ROWS));
        zx = 0;
        zy = 0;
        n  = 0;
        while (n < mirror_limit)
        begin
            xx = (zx * zx) >>> mbe_pkg::FRACTION_BITS;
            yy = (zy * zy) >>> mbe_pkg::FRACTION_BITS;
            if (xx + yy >= FOUR_FIX)
                break;
            nx = clamp(xx - yy + cx, Z_LOW, Z_HIGH);
            ny = clamp(((zx * zy) >>> (mbe_pkg::FRACTION_BITS - 1)) + cy, Z_LOW, Z_HIGH);
            zx = nx;
            zy = ny;
            n++;
        end
        return n[7:0];
    endfunction

    // Mostly back-to-back, some short gaps and a few long ones.
    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 93)
            return $urandom_range(1, 8);
        return $urandom_range(20, 280);
    endfunction

    // Register write; the caller lowers cfg_write once its burst is over.
    task automatic write_reg(logic [1:0] idx, logic [29:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        unique case (idx)
            mbe_pkg::REG_X_ORIGIN:        mirror_x_origin = longint'($signed(value));
            mbe_pkg::REG_Y_ORIGIN:        mirror_y_origin = longint'($signed(value));
            mbe_pkg::REG_STEP_SIZE:       mirror_step     = longint'(value[27:0]);
            mbe_pkg::REG_ITERATION_LIMIT: mirror_limit    = int'(value[7:0]);
            default: ;
        endcase
    endtask

    // Offer one pixel word and hold it until the unit takes it.
    task automatic send_pixel(mbe_pkg::pixel_t px, logic has_known,
                              logic [7:0] known_count);
        mbe_pkg::result_t want;
        start <= 1'b1;
        pixel <= px;
        do
            @(posedge clk);
        while (busy);
        want.iteration_count = has_known ? known_count : escape_count(px);
        want.column_out      = px.column;
        want.row_out         = px.row;
        awaited_results.push_back(want);
    endtask

    task automatic pause_after(int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop sending and wait until every pending result word has come back.
    task automatic drain_results();
        start <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    // Random register set for one phase, mostly a view of the interesting
    // region, sometimes anything the fields can hold.
    task automatic load_random_view();
        logic [29:0] x_val;
        logic [29:0] y_val;
        logic [29:0] step_val;
        logic [29:0] limit_val;
        int          pick;
        pick = $urandom_range(0, 9);
        if (pick < 7)
        begin
            x_val = 30'(int'($urandom_range(0, 402653184)) - 335544320);
            y_val = 30'(int'($urandom_range(0, 268435456)) - 201326592);
        end
        else
        begin
            x_val = 30'($urandom());
            y_val = 30'($urandom());
        end
        pick = $urandom_range(0, 9);
        if (pick < 7)
            step_val = 30'($urandom_range(16384, 1048576));
        else if (pick < 9)
            step_val = 30'($urandom_range(0, 268435455));
        else
            step_val = 30'($urandom_range(0, 64));
        pick = $urandom_range(0, 9);
        if (pick == 0)
            limit_val = 30'($urandom_range(0, 3));
        else if (pick == 1)
            limit_val = 30'd255;
        else
            limit_val = 30'($urandom_range(1, 255));
        write_reg(mbe_pkg::REG_X_ORIGIN, x_val);
        write_reg(mbe_pkg::REG_Y_ORIGIN, y_val);
        write_reg(mbe_pkg::REG_STEP_SIZE, step_val);
        write_reg(mbe_pkg::REG_ITERATION_LIMIT, limit_val);
        cfg_write <= 1'b0;
    endtask

    // Result checker: every done strobe carries one word, taken at the edge.
    always @(posedge clk)
    begin
        mbe_pkg::result_t want;
        if (rst_n && done)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("result for column %0d row %0d with no pixel pending",
                       result.column_out, result.row_out);
                failures++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (result.iteration_count !== want.iteration_count)
                begin
                    $error("iteration_count: expected %0d, actual %0d",
                           want.iteration_count, result.iteration_count);
                    failures++;
                end
                if (result.column_out !== want.column_out)
                begin
                    $error("column_out: expected %0d, actual %0d",
                           want.column_out, result.column_out);
                    failures++;
                end
                if (result.row_out !== want.row_out)
                begin
                    $error("row_out: expected %0d, actual %0d",
                           want.row_out, result.row_out);
                    failures++;
                end
            end
        end
    end

    // Watchdog: too long without a word moving in either direction.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Stimulus: reset, directed plan, then random phases.
    initial
    begin
        mbe_pkg::pixel_t px;
        bit              steady;
        rst_n        = 1'b0;
        cfg_write    <= 1'b0;
        cfg_index    <= mbe_pkg::REG_X_ORIGIN;
        cfg_data     <= '0;
        start        <= 1'b0;
        pixel        <= '0;
        failures     = 0;
        stall_cycles = 0;
        cfg_open     = 1'b0;

        mirror_x_origin = longint'(mbe_pkg::X_ORIGIN_RST);
        mirror_y_origin = longint'(mbe_pkg::Y_ORIGIN_RST);
        mirror_step     = longint'(mbe_pkg::STEP_SIZE_RST);
        mirror_limit    = int'(mbe_pkg::ITERATION_LIMIT_RST);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed plan; registers change only once the unit is idle.
        for (int k = 0; k < PLAN_ROWS; k++)
        begin
            if (directed_plan[k].kind == ROW_CONFIG)
            begin
                if (!cfg_open)
                    drain_results();
                write_reg(directed_plan[k].reg_index, directed_plan[k].value);
                cfg_open = 1'b1;
            end
            else
            begin
                if (cfg_open)
                begin
                    cfg_write <= 1'b0;
                    cfg_open = 1'b0;
                end
                px.column = directed_plan[k].column;
                px.row    = directed_plan[k].row;
                send_pixel(px, directed_plan[k].has_known, directed_plan[k].known_count);
                if (k + 1 < PLAN_ROWS && directed_plan[k + 1].kind == ROW_PIXEL)
                    pause_after(gap_length());
            end
        end

        // Random phases, each under its own register set.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain_results();
            load_random_view();
            steady = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < PHASE_PIXELS; k++)
            begin
                px.column = 10'($urandom_range(0, 1023));
                px.row    = 10'($urandom_range(0, 1023));
                send_pixel(px, 1'b0, 8'd0);
                if (!steady)
                    pause_after(gap_length());
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[sim.f]
sv/mbe_pkg.sv
sv/mbe_regs.sv
sv/mbe_ctrl.sv
sv/mbe_dp.sv
sv/mandelbrot_escape_time.sv
test/mandelbrot_escape_time_test.sv
